@@ hw/rtl/xalu_pkg.sv @@
// Package for the 8086-style integer ALU: opcodes, flag bit positions and helpers.
// Used by xalu_divider and x86_integer_alu_with_flags; no dependencies.
package xalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADC  = 4'd1,
    OP_SUB  = 4'd2,
    OP_SBB  = 4'd3,
    OP_CMP  = 4'd4,
    OP_MUL  = 4'd5,
    OP_IMUL = 4'd6,
    OP_DIV  = 4'd7,
    OP_IDIV = 4'd8
  } opcode_t;

  localparam int FL_CF = 0;
  localparam int FL_PF = 1;
  localparam int FL_AF = 2;
  localparam int FL_ZF = 3;
  localparam int FL_SF = 4;
  localparam int FL_OF = 5;

  localparam int DIV_BITS = 32;

  localparam logic [0:0] REG_CPU_MODE = 1'b0;

  // Even parity of a byte.
  function automatic logic even_parity(input logic [7:0] v);
    even_parity = ~(^v);
  endfunction

endpackage

@@ hw/rtl/xalu_divider.sv @@
// Unsigned restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// Depends on xalu_pkg.
module xalu_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [16:0] remainder
);
  import xalu_pkg::*;

  logic [4:0]  count;
  logic        busy;
  logic [16:0] trial;
  logic [17:0] diff;

  assign trial = {remainder[15:0], quotient[31]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= 5'(DIV_BITS - 1);
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (!diff[17]) begin
          remainder <= diff[16:0];
          quotient  <= {quotient[30:0], 1'b1};
        end else begin
          remainder <= trial;
          quotient  <= {quotient[30:0], 1'b0};
        end
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 5'd1;
        end
      end
    end
  end
endmodule

@@ hw/rtl/x86_integer_alu_with_flags.sv @@
// 8086 integer ALU with a kept six-bit flag register; top level.
// Add, subtract and compare finish in S_EXEC, multiplies pass through S_MUL, and divides wait in S_DIV
// (32 shared-divider steps, one quotient bit a cycle) before the sign fix-up in S_FIX.
// Throughput: one request at a time; a new request is taken once the last
// result has been handed over. Reset (rst, synchronous) clears the flags and cpu_model.
// Depends on xalu_pkg and xalu_divider.
module x86_integer_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: opcode[3:0], wide[4], dest_low[20:5], dest_high[36:21], source[52:37]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: result_low[15:0], result_high[31:16], write_back[32], divide_error[33],
  // carry[34], parity[35], aux_carry[36], zero[37], sign[38], overflow[39]
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xalu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_FIX, S_OUT} state_t;

  state_t      state;
  logic        cpu_model;
  logic [5:0]  flag_bits;
  logic [3:0]  op;
  logic        wide;
  logic [15:0] dl, dh, src;
  logic [31:0] prod;
  logic        neg_q, neg_r;
  logic [15:0] res_lo, res_hi;
  logic        wb, de;

  // Configuration port: a single register at address zero.
  assign pready = 1'b1;
  assign prdata = {31'd0, cpu_model};
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_model <= 1'b0;
    end else if (psel && penable && pwrite && paddr[1:0] == {REG_CPU_MODE, 1'b0}) begin
      cpu_model <= pwdata[0];
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {flag_bits[FL_OF], flag_bits[FL_SF], flag_bits[FL_ZF],
                     flag_bits[FL_AF], flag_bits[FL_PF], flag_bits[FL_CF],
                     de, wb, res_hi, res_lo};

  // Operands masked to the operand width; the multiply operands below are 17 bits, sign-extended for IMUL.
  logic [15:0] mask, d_m, s_m;
  logic        top_d, top_s;
  assign mask  = wide ? 16'hFFFF : 16'h00FF;
  assign d_m   = dl & mask;
  assign s_m   = src & mask;
  assign top_d = wide ? dl[15] : dl[7];
  assign top_s = wide ? src[15] : src[7];

  // Add and subtract path, 17 bits to keep the carry.
  logic        cin, is_add;
  logic [16:0] sum;
  logic        of_as;
  logic [15:0] r16;
  assign is_add = (op == OP_ADD) || (op == OP_ADC);
  assign cin    = ((op == OP_ADC) || (op == OP_SBB)) ? flag_bits[FL_CF] : 1'b0;
  assign sum    = is_add ? ({1'b0, d_m} + {1'b0, s_m} + {16'd0, cin})
                         : ({1'b0, d_m} - {1'b0, s_m} - {16'd0, cin});
  assign r16    = sum[15:0];
  always_comb begin
    logic rt;
    rt = wide ? r16[15] : r16[7];
    of_as = is_add ? ((rt ^ top_d) & (rt ^ top_s)) : ((top_d ^ top_s) & (top_d ^ rt));
  end

  // Signed multiply operands; the product is registered before the flag logic.
  logic signed [16:0] md, ms;
  logic signed [33:0] mprod;
  assign md    = (op == OP_IMUL) ? $signed({top_d, (wide ? dl : {{8{dl[7]}}, dl[7:0]})})
                                 : $signed({1'b0, d_m});
  assign ms    = (op == OP_IMUL) ? $signed({top_s, (wide ? src : {{8{src[7]}}, src[7:0]})})
                                 : $signed({1'b0, s_m});
  assign mprod = md * ms;

  // Division: magnitudes into the shared divider, signs restored afterwards.
  logic [31:0] dividend_s, div_a;
  logic [15:0] divisor_s, div_b;
  logic        sgn_a, sgn_b, div_start, div_done;
  logic [31:0] quo;
  logic [16:0] rem;
  assign dividend_s = wide ? {dh, dl} : {16'd0, dl};
  assign divisor_s  = s_m;
  assign sgn_a = (op == OP_IDIV) && (wide ? dh[15] : dl[15]);
  assign sgn_b = (op == OP_IDIV) && top_s;
  assign div_a = sgn_a ? (wide ? (~dividend_s + 32'd1) : {16'd0, (~dl + 16'd1)}) : dividend_s;
  assign div_b = sgn_b ? ((~divisor_s + 16'd1) & mask) : divisor_s;
  assign div_start = (state == S_EXEC) && (op == OP_DIV || op == OP_IDIV) && (s_m != 16'd0);

  xalu_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  // Product flags from the registered product.
  logic [15:0] p_lo;
  logic        p_big, p_zero;
  always_comb begin
    p_lo = prod[15:0] & mask;
    if (op == OP_IMUL)
      p_big = wide ? (prod[31:15] != {17{prod[15]}}) : (prod[31:7] != {25{prod[7]}});
    else
      p_big = wide ? (prod[31:16] != 16'd0) : (prod[15:8] != 8'd0);
    p_zero = (cpu_model == 1'b0) ? (prod == 32'd0) : (p_lo == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flag_bits <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[3:0];
            wide  <= s_tdata[4];
            dl    <= s_tdata[20:5];
            dh    <= s_tdata[36:21];
            src   <= s_tdata[52:37];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_lo <= '0;
          res_hi <= '0;
          wb     <= 1'b0;
          de     <= 1'b0;
          if (op <= OP_CMP) begin
            res_lo <= r16 & mask;
            wb     <= (op != OP_CMP);
            flag_bits[FL_CF] <= wide ? sum[16] : sum[8];
            flag_bits[FL_PF] <= even_parity(r16[7:0]);
            flag_bits[FL_AF] <= r16[4] ^ dl[4] ^ src[4];
            flag_bits[FL_ZF] <= (r16 & mask) == 16'd0;
            flag_bits[FL_SF] <= wide ? r16[15] : r16[7];
            flag_bits[FL_OF] <= of_as;
            state <= S_OUT;
          end else if (op == OP_MUL || op == OP_IMUL) begin
            prod  <= mprod[31:0];
            state <= S_MUL;
          end else if (op == OP_DIV || op == OP_IDIV) begin
            if (s_m == 16'd0) begin
              de    <= 1'b1;
              state <= S_OUT;
            end else begin
              neg_q <= sgn_a ^ sgn_b;
              neg_r <= sgn_a;
              state <= S_DIV;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_MUL: begin
          res_lo <= prod[15:0];
          res_hi <= wide ? prod[31:16] : 16'd0;
          wb     <= 1'b1;
          flag_bits[FL_CF] <= p_big;
          flag_bits[FL_OF] <= p_big;
          flag_bits[FL_PF] <= even_parity(prod[7:0]);
          flag_bits[FL_AF] <= prod[4] ^ md[4] ^ ms[4];
          flag_bits[FL_ZF] <= (op == OP_MUL) ? p_zero : (p_lo == 16'd0);
          flag_bits[FL_SF] <= wide ? prod[15] : prod[7];
          state <= S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          res_lo <= (neg_q ? (~quo[15:0] + 16'd1) : quo[15:0]) & mask;
          res_hi <= (neg_r ? (~rem[15:0] + 16'd1) : rem[15:0]) & mask;
          wb     <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ test/x86_integer_alu_with_flags_test.sv @@
// Self-checking testbench for the 8086-style integer ALU with kept flags.
// Depends on xalu_pkg and x86_integer_alu_with_flags; drives requests and checks every result.
module x86_integer_alu_with_flags_test;
  import xalu_pkg::*;

  // One result item: the field layout of m_tdata.
  typedef struct packed {
    logic        overflow;
    logic        sign;
    logic        zero;
    logic        aux_carry;
    logic        parity;
    logic        carry;
    logic        divide_error;
    logic        write_back;
    logic [15:0] result_high;
    logic [15:0] result_low;
  } alu_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  x86_integer_alu_with_flags uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The predictor's own copy of the block's state.
  logic [5:0]   flags_model;
  logic         model_sel;
  alu_result_t  pending_results[$];
  int           failures;
  int           requests_sent;
  int           results_seen;
  int           op_counts[9];
  int           burst_left;
  logic         hold_output = 1'b0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Works out the result of one request and updates the flag copy, exactly as
  // the block must: add-type flags, multiply significance, divide truncation.
  function automatic alu_result_t predict_alu(input logic [3:0] op, input logic wd,
                                              input logic [15:0] dl, input logic [15:0] dh,
                                              input logic [15:0] src);
    alu_result_t      r;
    logic [15:0]      msk;
    int               topb;
    logic [31:0]      d, s, sum, p;
    logic             cin, ovf;
    logic [5:0]       f;
    longint           sdd, sds, sq, sr, sp;
    logic [31:0]      dvd;
    msk  = wd ? 16'hFFFF : 16'h00FF;
    topb = wd ? 15 : 7;
    r    = '0;
    f    = flags_model;
    d    = {16'h0000, dl & msk};
    s    = {16'h0000, src & msk};
    if (op <= OP_CMP) begin
      cin = (op == OP_ADC || op == OP_SBB) ? flags_model[FL_CF] : 1'b0;
      if (op <= OP_ADC) begin
        sum = d + s + cin;
        ovf = (sum[topb] ^ d[topb]) & (sum[topb] ^ s[topb]);
      end else begin
        sum = d - s - cin;
        ovf = (d[topb] ^ s[topb]) & (d[topb] ^ sum[topb]);
      end
      f = '0;
      f[FL_CF] = sum[topb + 1];
      f[FL_PF] = ~(^sum[7:0]);
      f[FL_AF] = sum[4] ^ d[4] ^ s[4];
      f[FL_ZF] = ((sum[15:0] & msk) == 16'h0000);
      f[FL_SF] = sum[topb];
      f[FL_OF] = ovf;
      r.result_low = sum[15:0] & msk;
      r.write_back = (op != OP_CMP);
    end else if (op == OP_MUL || op == OP_IMUL) begin
      if (op == OP_MUL) begin
        p = d * s;
      end else begin
        sp = wd ? longint'($signed(dl)) * longint'($signed(src))
                : longint'($signed(dl[7:0])) * longint'($signed(src[7:0]));
        p = sp[31:0];
        d = wd ? {{16{dl[15]}}, dl} : {{24{dl[7]}}, dl[7:0]};
        s = wd ? {{16{src[15]}}, src} : {{24{src[7]}}, src[7:0]};
      end
      f = '0;
      f[FL_PF] = ~(^p[7:0]);
      f[FL_AF] = p[4] ^ d[4] ^ s[4];
      f[FL_SF] = p[topb];
      if (op == OP_MUL) begin
        f[FL_ZF] = model_sel ? ((p[15:0] & msk) == 16'h0000) : (p == 32'h0);
        f[FL_CF] = wd ? (p[31:16] != 16'h0000) : (p[15:8] != 8'h00);
      end else begin
        f[FL_ZF] = ((p[15:0] & msk) == 16'h0000);
        f[FL_CF] = wd ? (sp > 32767 || sp < -32768) : (sp > 127 || sp < -128);
      end
      f[FL_OF] = f[FL_CF];
      r.result_low  = p[15:0];
      r.result_high = wd ? p[31:16] : 16'h0000;
      r.write_back  = 1'b1;
    end else if (op == OP_DIV) begin
      dvd = wd ? {dh, dl} : {16'h0000, dl};
      if (s == 0) begin
        r.divide_error = 1'b1;
      end else begin
        r.result_low  = 16'((dvd / s) & {16'h0000, msk});
        r.result_high = 16'((dvd % s) & {16'h0000, msk});
        r.write_back  = 1'b1;
      end
    end else if (op == OP_IDIV) begin
      sdd = wd ? longint'($signed({dh, dl})) : longint'($signed(dl));
      sds = wd ? longint'($signed(src)) : longint'($signed(src[7:0]));
      if (sds == 0) begin
        r.divide_error = 1'b1;
      end else begin
        sq = sdd / sds;
        sr = sdd % sds;
        r.result_low  = sq[15:0] & msk;
        r.result_high = sr[15:0] & msk;
        r.write_back  = 1'b1;
      end
    end
    flags_model    = f;
    r.carry        = f[FL_CF];
    r.parity       = f[FL_PF];
    r.aux_carry    = f[FL_AF];
    r.zero         = f[FL_ZF];
    r.sign         = f[FL_SF];
    r.overflow     = f[FL_OF];
    return r;
  endfunction

  // Sends one request, with the sender working in random bursts and gaps.
  // The block is never ready in the cycle after it takes a request, so
  // dropping tvalid for that cycle costs nothing.
  task automatic send_request(input logic [3:0] op, input logic wd, input logic [15:0] dl,
                              input logic [15:0] dh, input logic [15:0] src);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, src, dh, dl, wd, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_alu(op, wd, dl, dh, src));
    requests_sent++;
    if (op <= OP_IDIV) op_counts[op]++;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected result and for the divider to settle.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register write over the configuration port: setup cycle, then access cycle.
  task automatic write_cpu_model(input logic val);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(REG_CPU_MODE) << 2;
    pwdata  <= {31'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_sel = val;
  endtask

  // Operand extremes for every operation, most in both widths, plus the special cases:
  // carry-in wrap, zero divisor, oversized quotient, negative division, and compare.
  task automatic test_directed_extremes();
    send_request(OP_ADD, 1'b0, 16'h00FF, 16'h0000, 16'h0001);
    send_request(OP_ADC, 1'b0, 16'h00FF, 16'h0000, 16'h00FF);
    send_request(OP_ADC, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(OP_SUB, 1'b1, 16'h8000, 16'h0000, 16'h0001);
    send_request(OP_SBB, 1'b0, 16'h0000, 16'h0000, 16'h00FF);
    send_request(OP_SBB, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_request(OP_CMP, 1'b1, 16'h1234, 16'h0000, 16'h1234);
    send_request(OP_CMP, 1'b0, 16'hFF7F, 16'hFFFF, 16'hFF80);
    send_request(OP_MUL, 1'b0, 16'h00FF, 16'h0000, 16'h00FF);
    send_request(OP_MUL, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(OP_MUL, 1'b1, 16'h0000, 16'h0000, 16'h1234);
    send_request(OP_MUL, 1'b1, 16'h0100, 16'h0000, 16'h0100);
    send_request(OP_IMUL, 1'b0, 16'h0080, 16'h0000, 16'h0080);
    send_request(OP_IMUL, 1'b0, 16'h00FF, 16'h0000, 16'h0080);
    send_request(OP_IMUL, 1'b1, 16'h8000, 16'h0000, 16'hFFFF);
    send_request(OP_DIV, 1'b0, 16'hFFFF, 16'h0000, 16'h0001);
    send_request(OP_DIV, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_DIV, 1'b1, 16'h1234, 16'h5678, 16'h0000);
    send_request(OP_IDIV, 1'b1, 16'h0000, 16'h8000, 16'hFFFF);
    send_request(OP_IDIV, 1'b0, 16'hFF81, 16'h0000, 16'h0007);
    send_request(OP_IDIV, 1'b0, 16'h8000, 16'h0000, 16'h0000);
    send_request(4'd9, 1'b1, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_request(4'd15, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // Random requests: mostly valid opcodes with operands biased to extremes.
  task automatic test_random_requests(input int count);
    logic [3:0]  op;
    logic [15:0] opnd[3];
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 7))
          0: opnd[k] = 16'h0000;
          1: opnd[k] = 16'hFFFF;
          2: opnd[k] = 16'h8000 | 16'($urandom_range(0, 1));
          3: opnd[k] = 16'($urandom_range(0, 15));
          default: opnd[k] = 16'($urandom);
        endcase
      end
      // Keep word divides mostly in range so real quotients are exercised.
      if ((op == OP_DIV || op == OP_IDIV) && $urandom_range(0, 2) != 0 && opnd[2] != 0)
        opnd[1] = opnd[1] % opnd[2];
      send_request(op, 1'($urandom), opnd[0], opnd[1], opnd[2]);
      if (i == count / 2) drain_results();
    end
  endtask

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = alu_result_t'(m_tdata);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.result_low !== want.result_low ||
            got.result_high !== want.result_high ||
            got.write_back !== want.write_back ||
            got.divide_error !== want.divide_error ||
            got.carry !== want.carry || got.parity !== want.parity ||
            got.aux_carry !== want.aux_carry || got.zero !== want.zero ||
            got.sign !== want.sign || got.overflow !== want.overflow) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          failures++;
        end
      end
    end
  end

  // The receiver stalls on its own pattern: quiet stretches alternate with busy ones.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) hold_output <= ~hold_output;
    m_tready <= hold_output ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    flags_model = '0; model_sel = 1'b0; failures = 0;
    requests_sent = 0; results_seen = 0; burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    write_cpu_model(1'b1);
    test_directed_extremes();
    test_random_requests(300);
    write_cpu_model(1'b0);
    test_random_requests(300);
    drain_results();
    $display("Covered %0d requests, %0d results.", requests_sent, results_seen);
    $display("Per opcode add..idiv: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             op_counts[0], op_counts[1], op_counts[2], op_counts[3], op_counts[4],
             op_counts[5], op_counts[6], op_counts[7], op_counts[8]);
    $display("Both cpu models were set, with random stalls on either side.");
    if (failures == 0 && pending_results.size() == 0) begin
      $display("x86_integer_alu_with_flags_test: PASS");
    end else begin
      $display("x86_integer_alu_with_flags_test: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("x86_integer_alu_with_flags_test: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/xalu_pkg.sv
hw/rtl/xalu_divider.sv
hw/rtl/x86_integer_alu_with_flags.sv
test/x86_integer_alu_with_flags_test.sv
